@@ src/assert_macros.svh @@
// Assertion macros included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every rising clock edge outside reset.
`define NA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define NA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/na_pkg.sv @@
// Types, constants and codes of the note arpeggiator.
package na_pkg;

  localparam int HELD_KEYS   = 8;
  localparam int MAX_OCTAVES = 4;
  localparam int LOOP_DEPTH  = 64;
  localparam int SEMITONES   = 12;

  localparam int CELLS   = HELD_KEYS * MAX_OCTAVES;
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int NCNT_W  = $clog2(CELLS + 1);
  localparam int LEN_W   = $clog2(LOOP_DEPTH + 1);
  localparam int IDX_W   = $clog2(LOOP_DEPTH);
  localparam int KEY_AW  = (HELD_KEYS > 1) ? $clog2(HELD_KEYS) : 1;
  localparam int KCNT_W  = $clog2(HELD_KEYS + 1);
  localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);

  typedef enum logic [1:0] {
    REQ_PRESS   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_RESTART = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ORD_ASC    = 2'd0,
    ORD_DESC   = 2'd1,
    ORD_UPDOWN = 2'd2,
    ORD_PRESS  = 2'd3
  } order_e;

  typedef enum logic [1:0] {
    CFG_PLAY_ORDER = 2'd0,
    CFG_OCTAVES    = 2'd1,
    CFG_DYN_RATE   = 2'd2,
    CFG_BASE_RATE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NUDGE,
    ST_FEED,
    ST_FINISH,
    ST_TICK
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] note;
  } req_t;

  typedef struct packed {
    logic [7:0] played_note;
    logic [3:0] held_count;
    logic [6:0] loop_size;
    logic [7:0] step_rate;
  } res_t;

  // Control broadcast to every sort cell.
  typedef struct packed {
    logic       clear;
    logic       ins;
    order_e     order;
    logic [7:0] v;
  } ins_t;

  // Content handed from one cell to the next.
  typedef struct packed {
    logic       valid;
    logic [7:0] val;
  } cell_link_t;

endpackage

@@ src/na_sort_cell.sv @@
// One cell of the insertion chain that holds the sorted loop notes.
module na_sort_cell import na_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ins_t       ctl_i,
  input  logic       prev_keep_i,
  input  cell_link_t prev_i,
  output cell_link_t cell_o,
  output logic       keep_o
);

  cell_link_t cell_q;
  logic       stays;

  // Decide whether the held note stays in front of the new one
  always_comb begin
    unique case (ctl_i.order)
      ORD_ASC, ORD_UPDOWN: stays = (cell_q.val <= ctl_i.v);
      ORD_DESC:            stays = (cell_q.val >= ctl_i.v);
      default:             stays = 1'b1;
    endcase
  end

  assign keep_o = cell_q.valid && stays;
  assign cell_o = cell_q;

  // Clear, hold, take the new note, or shift in the neighbor's note
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (ctl_i.clear) begin
      cell_q.valid <= 1'b0;
    end else if (ctl_i.ins && !keep_o) begin
      if (prev_keep_i) begin
        cell_q.valid <= 1'b1;
        cell_q.val   <= ctl_i.v;
      end else begin
        cell_q <= prev_i;
      end
    end
  end

endmodule

@@ src/note_arpeggiator_top.sv @@
// Top level of the note arpeggiator: key store, sort chain and play control.
//
// Channel   Direction  Handshake                    Payload
// request   in         start & !busy                req_i (req_t)
// result    out        res_valid_o, one cycle       res_o (res_t)
// config    in         cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//
// Press or release: the index is nudged once per octave copy, each octave copy of
// each held note is fed to the sort chain, the feed is seen done and the loop is
// finished, and then the result strobes. Restart skips the nudge. A tick answers
// once the advanced index is wrapped; ignored keys answer straight from idle.
// Reset is asynchronous, active low, no clearing pass.
// The receiver cannot stall results; a new request may be accepted while one shows.
module note_arpeggiator_top import na_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  output logic       res_valid_o,
  output res_t       res_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

`include "assert_macros.svh"

  state_e            state_q, state_d;
  order_e            order_q, order_d;
  logic [OCT_W-1:0]  oct_q, oct_d;
  logic              dyn_q, dyn_d;
  logic [6:0]        held_q [HELD_KEYS];
  logic [6:0]        held_d [HELD_KEYS];
  logic [KCNT_W-1:0] total_q, total_d;
  logic [NCNT_W-1:0] n_q, n_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              up_q, up_d;
  logic [7:0]        rate_q, rate_d;
  logic [OCT_W-1:0]  k_q, k_d;
  logic [7:0]        nnote_q, nnote_d;
  logic              rel_q, rel_d;
  logic [KCNT_W-1:0] fi_q, fi_d;
  logic [LEN_W-1:0]  m_q, m_d;
  logic [7:0]        played_q, played_d;
  logic              res_req_q, res_req_d;
  logic              res_valid_q, res_valid_d;

  ins_t              ctl;
  cell_link_t        cells [CELLS];
  logic              keep [CELLS];

  logic              accept, cfg_fire;
  logic [7:0]        cur_note;
  logic [LEN_W-1:0]  rd_pos, rd_mirror;
  logic [CELL_AW-1:0] rd_addr;
  logic              asc, desc;
  logic [HELD_KEYS-1:0] pre_match;
  logic [LEN_W-1:0]  nidx;
  logic [2:0]        oct_raw;
  int                full_len;

  // Sort chain
  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    if (g == 0) begin : g_head
      na_sort_cell u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl), .prev_keep_i(1'b1), .prev_i('0),
        .cell_o(cells[g]), .keep_o(keep[g])
      );
    end else begin : g_body
      na_sort_cell u_cell (
        .clk_i, .rst_ni, .ctl_i(ctl), .prev_keep_i(keep[g-1]), .prev_i(cells[g-1]),
        .cell_o(cells[g]), .keep_o(keep[g])
      );
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy && !start;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // Read the loop note under the play index; the second half mirrors
  always_comb begin
    rd_pos    = LEN_W'(idx_q);
    rd_mirror = LEN_W'({n_q, 1'b0}) - LEN_W'(1) - rd_pos;
    if (rd_pos < LEN_W'(n_q)) begin
      rd_addr = rd_pos[CELL_AW-1:0];
    end else begin
      rd_addr = rd_mirror[CELL_AW-1:0];
    end
    if (rd_pos >= len_q) begin
      cur_note = '0;
    end else begin
      cur_note = cells[rd_addr].val;
    end
  end

  assign asc  = (order_q == ORD_ASC)  || ((order_q == ORD_UPDOWN) && up_q);
  assign desc = (order_q == ORD_DESC) || ((order_q == ORD_UPDOWN) && !up_q);

  // Mark the first held slot that matches the released note and all after it
  always_comb begin
    pre_match[0] = (held_q[0] == req_i.note);
    for (int i = 1; i < HELD_KEYS; i++) begin
      pre_match[i] = pre_match[i-1] || (held_q[i] == req_i.note);
    end
  end

  // Next state and control
  always_comb begin
    state_d     = state_q;
    order_d     = order_q;
    oct_d       = oct_q;
    dyn_d       = dyn_q;
    held_d      = held_q;
    total_d     = total_q;
    n_d         = n_q;
    len_d       = len_q;
    idx_d       = idx_q;
    up_d        = up_q;
    rate_d      = rate_q;
    k_d         = k_q;
    nnote_d     = nnote_q;
    rel_d       = rel_q;
    fi_d        = fi_q;
    m_d         = m_q;
    played_d    = played_q;
    res_req_d   = res_req_q;
    res_valid_d = 1'b0;
    ctl.clear   = 1'b0;
    ctl.ins     = 1'b0;
    ctl.order   = order_q;
    ctl.v       = 8'({1'b0, held_q[fi_q[KEY_AW-1:0]]} + 8'(int'(k_q) * SEMITONES));
    nidx        = '0;
    oct_raw     = cfg_data_i[2:0];
    full_len    = 0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          played_d  = '0;
          res_req_d = 1'b1;
          k_d       = '0;
          nnote_d   = {1'b0, req_i.note};
          unique case (req_e'(req_i.req_type))
            REQ_PRESS: begin
              if ((req_i.note != '0) && (total_q < KCNT_W'(HELD_KEYS))) begin
                held_d[total_q[KEY_AW-1:0]] = req_i.note;
                total_d = total_q + KCNT_W'(1);
                rel_d   = 1'b0;
                state_d = ST_NUDGE;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            REQ_RELEASE: begin
              if ((req_i.note != '0) && pre_match[HELD_KEYS-1]) begin
                for (int i = 0; i < HELD_KEYS; i++) begin
                  if (pre_match[i]) begin
                    held_d[i] = (i < HELD_KEYS - 1) ? held_q[(i+1) % HELD_KEYS] : '0;
                  end
                end
                if (total_q != '0) begin
                  total_d = total_q - KCNT_W'(1);
                end
                rel_d   = 1'b1;
                state_d = ST_NUDGE;
              end else begin
                res_valid_d = 1'b1;
              end
            end
            REQ_TICK: begin
              played_d = cur_note;
              m_d      = (len_q == '0) ? '0 : LEN_W'(idx_q) + LEN_W'(1);
              state_d  = ST_TICK;
            end
            default: begin
              idx_d     = '0;
              up_d      = 1'b1;
              ctl.clear = 1'b1;
              n_d       = '0;
              fi_d      = '0;
              state_d   = ST_FEED;
            end
          endcase
        end else if (cfg_fire) begin
          unique case (cfg_idx_e'(cfg_index_i))
            CFG_PLAY_ORDER, CFG_OCTAVES: begin
              if (cfg_idx_e'(cfg_index_i) == CFG_PLAY_ORDER) begin
                order_d = order_e'(cfg_data_i[1:0]);
              end else if (oct_raw == 3'd0) begin
                oct_d = OCT_W'(1);
              end else if (int'(oct_raw) > MAX_OCTAVES) begin
                oct_d = OCT_W'(MAX_OCTAVES);
              end else begin
                oct_d = OCT_W'(oct_raw);
              end
              res_req_d = 1'b0;
              idx_d     = '0;
              up_d      = 1'b1;
              ctl.clear = 1'b1;
              n_d       = '0;
              fi_d      = '0;
              k_d       = '0;
              state_d   = ST_FEED;
            end
            CFG_DYN_RATE: dyn_d = cfg_data_i[0];
            default:      rate_d = (cfg_data_i == '0) ? 8'd1 : cfg_data_i;
          endcase
        end
      end

      ST_NUDGE: begin
        // Step the index once per octave copy against the old loop
        if (rel_q) begin
          if (((asc && (nnote_q < cur_note)) || (desc && (nnote_q > cur_note)))
              && (idx_q != '0)) begin
            nidx = LEN_W'(idx_q) - LEN_W'(1);
          end else begin
            nidx = LEN_W'(idx_q);
          end
        end else begin
          if ((cur_note != '0)
              && ((asc && (nnote_q <= cur_note)) || (desc && (nnote_q >= cur_note)))) begin
            nidx = LEN_W'(idx_q) + LEN_W'(1);
          end else begin
            nidx = LEN_W'(idx_q);
          end
        end
        if ((nidx == '0) || (nidx >= len_q)) begin
          idx_d = '0;
        end else begin
          idx_d = nidx[IDX_W-1:0];
        end
        nnote_d = nnote_q + 8'(SEMITONES);
        if (k_q == oct_q - OCT_W'(1)) begin
          k_d       = '0;
          ctl.clear = 1'b1;
          n_d       = '0;
          fi_d      = '0;
          state_d   = ST_FEED;
        end else begin
          k_d = k_q + OCT_W'(1);
        end
      end

      ST_FEED: begin
        // Insert one octave copy of one held key per cycle
        if (fi_q >= total_q) begin
          state_d = ST_FINISH;
        end else begin
          ctl.ins = 1'b1;
          n_d     = n_q + NCNT_W'(1);
          if (k_q == oct_q - OCT_W'(1)) begin
            k_d  = '0;
            fi_d = fi_q + KCNT_W'(1);
          end else begin
            k_d = k_q + OCT_W'(1);
          end
        end
      end

      ST_FINISH: begin
        full_len = (order_q == ORD_UPDOWN) ? 2 * int'(n_q) : int'(n_q);
        if (full_len > LOOP_DEPTH) begin
          full_len = LOOP_DEPTH;
        end
        len_d = LEN_W'(full_len);
        if (dyn_q) begin
          rate_d = (total_q == '0) ? 8'd1 : 8'(total_q);
        end
        res_valid_d = res_req_q;
        state_d     = ST_IDLE;
      end

      ST_TICK: begin
        // Wrap the advanced index by repeated subtraction
        if ((len_q != '0) && (m_q >= len_q)) begin
          m_d = m_q - len_q;
        end else begin
          idx_d = m_q[IDX_W-1:0];
          if (order_q == ORD_UPDOWN) begin
            if (up_q && (m_q >= (len_q >> 1))) begin
              up_d = 1'b0;
            end else if (!up_q && (m_q < (len_q >> 1))) begin
              up_d = 1'b1;
            end
          end
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      order_q     <= ORD_ASC;
      oct_q       <= OCT_W'(1);
      dyn_q       <= 1'b0;
      held_q      <= '{default: '0};
      total_q     <= '0;
      n_q         <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      up_q        <= 1'b1;
      rate_q      <= 8'd1;
      k_q         <= '0;
      rel_q       <= 1'b0;
      fi_q        <= '0;
      res_req_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      order_q     <= order_d;
      oct_q       <= oct_d;
      dyn_q       <= dyn_d;
      held_q      <= held_d;
      total_q     <= total_d;
      n_q         <= n_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      up_q        <= up_d;
      rate_q      <= rate_d;
      k_q         <= k_d;
      rel_q       <= rel_d;
      fi_q        <= fi_d;
      res_req_q   <= res_req_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    nnote_q  <= nnote_d;
    m_q      <= m_d;
    played_q <= played_d;
  end

  assign res_valid_o       = res_valid_q;
  assign res_o.played_note = played_q;
  assign res_o.held_count  = 4'(total_q);
  assign res_o.loop_size   = 7'(len_q);
  assign res_o.step_rate   = rate_q;

  `NA_ASSERT(a_res_when_idle, !res_valid_q || (state_q == ST_IDLE), "result while busy")
  `NA_ASSERT(a_held_bound, total_q <= KCNT_W'(HELD_KEYS), "held count out of range")
  `NA_ASSERT(a_len_bound, int'(len_q) <= LOOP_DEPTH, "loop length out of range")
  `NA_ASSERT_NEXT(a_tick_busy, accept && (req_i.req_type == REQ_TICK), busy,
                  "tick did not start")

endmodule
